[rtl/assert_macros.svh]
// Assertion macros used by the top level of the transform block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("assertion failed: invariant");

// A consequence that must hold in the same cycle as its antecedent.
`define ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// A consequence that must hold in the cycle after its antecedent.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

[rtl/fwhtgs_pkg.sv]
// Package with the payload types and fixed constants of the transform block.
package fwhtgs_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int VALUE_W    = 24;
   localparam int SCALE_W    = 16;
   localparam int LOG_W      = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_LOG_GROUP_SIZE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_Q16      = 1'd1;

   localparam logic [LOG_W-1:0]   LOG_GROUP_SIZE_RESET = 3'd7;
   localparam logic [SCALE_W-1:0] SCALE_Q16_RESET      = 16'd5793;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_even;
      logic signed [SAMPLE_W-1:0] sample_odd;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value_even;
      logic signed [VALUE_W-1:0] value_odd;
      logic                      last_pair;
   } rsp_payload_type;

endpackage

[rtl/fwhtgs_bank.sv]
// One bank of the coefficient store: one write port and one registered read port.
module fwhtgs_bank #(
   parameter int AW = 6,
   parameter int DW = 23
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [2**AW];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/fwhtgs_bfly.sv]
// Shared butterfly unit: sum and difference of two coefficients, routed to the banks.
module fwhtgs_bfly #(
   parameter int EW = 23
) (
   input  logic                 swap,
   input  logic signed [EW-1:0] rd_data0,
   input  logic signed [EW-1:0] rd_data1,
   output logic signed [EW-1:0] wr_data0,
   output logic signed [EW-1:0] wr_data1
);

   logic signed [EW-1:0] op_a;
   logic signed [EW-1:0] op_b;
   logic signed [EW-1:0] sum;
   logic signed [EW-1:0] diff;

   // The lower index of the butterfly lives in bank 1 when swap is set.
   always_comb begin
      op_a     = swap ? rd_data1 : rd_data0;
      op_b     = swap ? rd_data0 : rd_data1;
      sum      = op_a + op_b;
      diff     = op_a - op_b;
      wr_data0 = swap ? diff : sum;
      wr_data1 = swap ? sum : diff;
   end

endmodule

[rtl/fwhtgs_scale.sv]
// Output scaling: Q0.16 multiply, floor shift by 16 and saturation to 24 bits.
module fwhtgs_scale #(
   parameter int EW = 23
) (
   input  logic                                    clock,
   input  logic                                    capture,
   input  logic signed [EW-1:0]                    coef_even,
   input  logic signed [EW-1:0]                    coef_odd,
   input  logic [fwhtgs_pkg::SCALE_W-1:0]          scale,
   output logic signed [fwhtgs_pkg::VALUE_W-1:0]   value_even,
   output logic signed [fwhtgs_pkg::VALUE_W-1:0]   value_odd
);

   localparam int PW = EW + fwhtgs_pkg::SCALE_W + 1;
   localparam int QW = PW - fwhtgs_pkg::SCALE_W;
   localparam int XW = (QW > fwhtgs_pkg::VALUE_W) ? QW : fwhtgs_pkg::VALUE_W;
   localparam int VW = fwhtgs_pkg::VALUE_W;

   logic signed [fwhtgs_pkg::SCALE_W:0] scale_s;
   logic signed [PW-1:0]                prod_even_ff;
   logic signed [PW-1:0]                prod_odd_ff;
   logic signed [PW-1:0]                prod_even_in;
   logic signed [PW-1:0]                prod_odd_in;

   // Dropping the low 16 bits of the two's complement product is a floor.
   function automatic logic signed [VW-1:0] saturate(input logic signed [PW-1:0] prod);
      logic signed [QW-1:0] q;
      logic signed [XW-1:0] qx;
      logic [XW-VW:0]       top;
      q   = prod[PW-1:fwhtgs_pkg::SCALE_W];
      qx  = XW'(q);
      top = qx[XW-1:VW-1];
      if ((&top) || !(|top)) begin
         saturate = qx[VW-1:0];
      end else if (qx[XW-1]) begin
         saturate = {1'b1, {(VW-1){1'b0}}};
      end else begin
         saturate = {1'b0, {(VW-1){1'b1}}};
      end
   endfunction

   always_comb begin
      scale_s      = $signed({1'b0, scale});
      prod_even_in = PW'(coef_even) * PW'(scale_s);
      prod_odd_in  = PW'(coef_odd) * PW'(scale_s);
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         prod_even_ff <= prod_even_in;
         prod_odd_ff  <= prod_odd_in;
      end
   end

   assign value_even = saturate(prod_even_ff);
   assign value_odd  = saturate(prod_odd_ff);

endmodule

[rtl/fwht_group_scale.sv]
// Top level of the scaled fast Walsh-Hadamard transform block with its sequencer.
//
// Usage: samples of one group arrive as pairs on the req_ channel (valid/ready),
// even index first in each pair, in natural index order. The group holds
// 2^log_group_size samples (an exponent of zero counts as one, and the size is
// capped at MAX_GROUP_SIZE). One req_ transaction is taken per cycle while the
// group fills. The transaction that completes the group starts the transform
// and req_ready drops until every result of the group has been handed over.
// The transform runs log2(size) passes through one shared butterfly unit, one
// butterfly per cycle, with a drain state closing each pass so that a pass only
// reads what the previous pass has written. The store is split into two banks
// by index parity, so both operands of every butterfly are read and written in
// the same cycle. Each output pair then goes through three steps (read,
// multiply, saturate). Results leave on the rsp_ channel as registered pairs,
// the last pair of the group marked by last_pair. When the receiver stalls,
// the result holds and the sequencer waits. Reset clears the pair count, the
// sequencer and the configuration registers to their defaults; no clearing
// pass is needed. Configuration writes on the csr_ port are meant to happen
// only while idle.
`include "assert_macros.svh"

module fwht_group_scale #(
   parameter int MAX_GROUP_SIZE = 128
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  fwhtgs_pkg::req_payload_type            req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output fwhtgs_pkg::rsp_payload_type            rsp_payload,
   input  logic                                   csr_we,
   input  logic [fwhtgs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fwhtgs_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int LOG_MAX = $clog2(MAX_GROUP_SIZE);
   localparam int IDX_W   = LOG_MAX;
   localparam int BANK_AW = (LOG_MAX > 1) ? LOG_MAX - 1 : 1;
   localparam int EW      = fwhtgs_pkg::SAMPLE_W + LOG_MAX;
   localparam int LOG_W   = fwhtgs_pkg::LOG_W;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_BFLY  = 6'b000010,
      S_DRAIN = 6'b000100,
      S_RD    = 6'b001000,
      S_MUL   = 6'b010000,
      S_PUT   = 6'b100000
   } state_type;

   // Each bank holds the entries whose index has one parity of its bits; the
   // address inside a bank is the index without its lowest bit.
   function automatic logic [BANK_AW-1:0] bank_addr(input logic [IDX_W-1:0] idx);
      bank_addr = BANK_AW'(idx >> 1);
   endfunction

   // Configuration registers.
   logic [LOG_W-1:0]                log_group_size_ff;
   logic [fwhtgs_pkg::SCALE_W-1:0]  scale_q16_ff;

   // Sequencer state.
   state_type                       state_ff, state_in;
   logic [6:0]                      pairs_loaded_ff, pairs_loaded_in;
   logic [LOG_W-1:0]                pass_ff, pass_in;
   logic [BANK_AW-1:0]              j_ff, j_in;
   logic [BANK_AW-1:0]              p_ff, p_in;
   logic                            rd_valid_ff, rd_valid_in;
   logic                            swap_ff, swap_in;
   logic [IDX_W-1:0]                k_ff, k_in;
   logic [IDX_W-1:0]                kb_ff, kb_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   fwhtgs_pkg::rsp_payload_type     rsp_payload_ff, rsp_payload_in;

   // Derived group geometry.
   logic [LOG_W-1:0]                log_nz;
   logic [LOG_W-1:0]                eff_log;
   logic [6:0]                      half;
   logic [6:0]                      pairs_inc;
   logic                            group_done;
   logic                            req_fire;
   logic                            put_go;
   logic                            last_j;
   logic                            last_pass;
   logic                            last_p;

   // Addressing.
   logic [IDX_W-1:0]                ld_idx;
   logic                            ld_par;
   logic [IDX_W-1:0]                jx;
   logic [IDX_W-1:0]                low_mask;
   logic [IDX_W-1:0]                bf_k;
   logic [IDX_W-1:0]                bf_kb;
   logic                            bf_par;
   logic [IDX_W-1:0]                out_idx;
   logic                            out_par;

   // Bank ports.
   logic                            bank_we;
   logic [BANK_AW-1:0]              waddr0, waddr1;
   logic [EW-1:0]                   wdata0, wdata1;
   logic [BANK_AW-1:0]              raddr0, raddr1;
   logic [EW-1:0]                   rdata0, rdata1;
   logic signed [EW-1:0]            bf_wdata0, bf_wdata1;
   logic signed [EW-1:0]            coef_even, coef_odd;
   logic signed [fwhtgs_pkg::VALUE_W-1:0] scaled_even, scaled_odd;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         log_group_size_ff <= fwhtgs_pkg::LOG_GROUP_SIZE_RESET;
         scale_q16_ff      <= fwhtgs_pkg::SCALE_Q16_RESET;
      end else if (csr_we) begin
         case (csr_index)
            fwhtgs_pkg::CSR_LOG_GROUP_SIZE: begin
               log_group_size_ff <= csr_wdata[LOG_W-1:0];
            end
            fwhtgs_pkg::CSR_SCALE_Q16: begin
               scale_q16_ff <= csr_wdata[fwhtgs_pkg::SCALE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Group size: an exponent of zero means a group of two, and the size is
   // capped at the store depth.
   always_comb begin
      log_nz     = (log_group_size_ff == '0) ? LOG_W'(1) : log_group_size_ff;
      eff_log    = (log_nz > LOG_W'(LOG_MAX)) ? LOG_W'(LOG_MAX) : log_nz;
      half       = 7'(8'd1 << (eff_log - LOG_W'(1)));
      pairs_inc  = pairs_loaded_ff + 7'd1;
      group_done = (pairs_inc >= half);
      req_fire   = req_valid && req_ready;
      put_go     = (state_ff == S_PUT) && (!rsp_valid_ff || rsp_ready);
      last_j     = (j_ff == BANK_AW'(half - 7'd1));
      last_pass  = (pass_ff == (eff_log - LOG_W'(1)));
      last_p     = (p_ff == BANK_AW'(half - 7'd1));
   end

   // Index arithmetic. A butterfly pairs k with k + span; the two differ in one
   // bit, so their bit parities differ and they always sit in opposite banks.
   always_comb begin
      ld_idx   = IDX_W'({pairs_loaded_ff, 1'b0});
      ld_par   = ^ld_idx;
      jx       = IDX_W'(j_ff);
      low_mask = IDX_W'((8'd1 << pass_ff) - 8'd1);
      bf_k     = ((jx & ~low_mask) << 1) | (jx & low_mask);
      bf_kb    = bf_k | IDX_W'(8'd1 << pass_ff);
      bf_par   = ^bf_k;
      out_idx  = IDX_W'({p_ff, 1'b0});
      out_par  = ^out_idx;
   end

   // Read addresses: a butterfly pass or an output pair. Both entries of an
   // output pair share one in-bank address.
   always_comb begin
      if (state_ff == S_BFLY) begin
         raddr0 = bf_par ? bank_addr(bf_kb) : bank_addr(bf_k);
         raddr1 = bf_par ? bank_addr(bf_k) : bank_addr(bf_kb);
      end else begin
         raddr0 = bank_addr(out_idx);
         raddr1 = bank_addr(out_idx);
      end
   end

   // Write side: loading a sample pair or the butterfly write-back.
   always_comb begin
      bank_we = req_fire || rd_valid_ff;
      if (rd_valid_ff) begin
         waddr0 = swap_ff ? bank_addr(kb_ff) : bank_addr(k_ff);
         waddr1 = swap_ff ? bank_addr(k_ff) : bank_addr(kb_ff);
         wdata0 = bf_wdata0;
         wdata1 = bf_wdata1;
      end else begin
         waddr0 = bank_addr(ld_idx);
         waddr1 = bank_addr(ld_idx);
         wdata0 = ld_par ? EW'(req_payload.sample_odd) : EW'(req_payload.sample_even);
         wdata1 = ld_par ? EW'(req_payload.sample_even) : EW'(req_payload.sample_odd);
      end
   end

   fwhtgs_bank #(.AW(BANK_AW), .DW(EW)) u_bank0 (
      .clock   (clock),
      .wr_en   (bank_we),
      .wr_addr (waddr0),
      .wr_data (wdata0),
      .rd_addr (raddr0),
      .rd_data (rdata0)
   );

   fwhtgs_bank #(.AW(BANK_AW), .DW(EW)) u_bank1 (
      .clock   (clock),
      .wr_en   (bank_we),
      .wr_addr (waddr1),
      .wr_data (wdata1),
      .rd_addr (raddr1),
      .rd_data (rdata1)
   );

   fwhtgs_bfly #(.EW(EW)) u_bfly (
      .swap     (swap_ff),
      .rd_data0 ($signed(rdata0)),
      .rd_data1 ($signed(rdata1)),
      .wr_data0 (bf_wdata0),
      .wr_data1 (bf_wdata1)
   );

   // The even entry of an output pair lives in bank 1 when swap is set.
   always_comb begin
      coef_even = swap_ff ? $signed(rdata1) : $signed(rdata0);
      coef_odd  = swap_ff ? $signed(rdata0) : $signed(rdata1);
   end

   fwhtgs_scale #(.EW(EW)) u_scale (
      .clock      (clock),
      .capture    (state_ff == S_MUL),
      .coef_even  (coef_even),
      .coef_odd   (coef_odd),
      .scale      (scale_q16_ff),
      .value_even (scaled_even),
      .value_odd  (scaled_odd)
   );

   // Sequencer.
   always_comb begin
      state_in        = state_ff;
      pairs_loaded_in = pairs_loaded_ff;
      pass_in         = pass_ff;
      j_in            = j_ff;
      p_in            = p_ff;
      rd_valid_in     = 1'b0;
      swap_in         = swap_ff;
      k_in            = k_ff;
      kb_in           = kb_ff;
      rsp_payload_in  = rsp_payload_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (group_done) begin
                  pairs_loaded_in = '0;
                  pass_in         = '0;
                  j_in            = '0;
                  state_in        = S_BFLY;
               end else begin
                  pairs_loaded_in = pairs_inc;
               end
            end
         end
         S_BFLY: begin
            rd_valid_in = 1'b1;
            swap_in     = bf_par;
            k_in        = bf_k;
            kb_in       = bf_kb;
            j_in        = j_ff + BANK_AW'(1);
            if (last_j) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // The last write-back of the pass lands in this cycle.
            j_in = '0;
            if (last_pass) begin
               p_in     = '0;
               state_in = S_RD;
            end else begin
               pass_in  = pass_ff + LOG_W'(1);
               state_in = S_BFLY;
            end
         end
         S_RD: begin
            swap_in  = out_par;
            state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_PUT;
         end
         S_PUT: begin
            if (put_go) begin
               rsp_valid_in              = 1'b1;
               rsp_payload_in.value_even = scaled_even;
               rsp_payload_in.value_odd  = scaled_odd;
               rsp_payload_in.last_pair  = last_p;
               if (last_p) begin
                  state_in = S_IDLE;
               end else begin
                  p_in     = p_ff + BANK_AW'(1);
                  state_in = S_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         pairs_loaded_ff <= '0;
         pass_ff         <= '0;
         j_ff            <= '0;
         p_ff            <= '0;
         rd_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         pairs_loaded_ff <= pairs_loaded_in;
         pass_ff         <= pass_in;
         j_ff            <= j_in;
         p_ff            <= p_in;
         rd_valid_ff     <= rd_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      swap_ff        <= swap_in;
      k_ff           <= k_in;
      kb_ff          <= kb_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // A write-back always follows a butterfly read in the previous cycle.
   `ASSERT_SAME(a_wb_after_read, rd_valid_ff, $past(state_ff == S_BFLY))
   // The pass counter never runs past the last pass of the configured group.
   `ASSERT_SAME(a_pass_in_range, state_ff == S_BFLY || state_ff == S_DRAIN, pass_ff < eff_log)
   // The butterfly counter stays inside one pass.
   `ASSERT_SAME(a_bfly_in_range, state_ff == S_BFLY, 7'(j_ff) < half)
   // Handing over the last pair of a group leaves the block idle with an empty count.
   `ASSERT_NEXT(a_group_closes, put_go && last_p, state_ff == S_IDLE && pairs_loaded_ff == '0)

endmodule
